// ===== hdl/spa_pkg.sv =====
// shared constants, types and codes of the page frame allocator
`default_nettype none
package spa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 16;
  localparam int FUP_W      = 12;
  localparam int PG_W       = $clog2(NUM_PAGES);
  localparam int DEP_W      = $clog2(NUM_PAGES + 1);
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  typedef logic [1:0]              func_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic signed [CNT_W-1:0] count_t;
  typedef logic [2:0]              status_t;
  typedef logic [PG_W-1:0]         page_t;
  typedef logic [DEP_W-1:0]        depth_t;
  typedef logic [FUP_W-1:0]        fup_t;
  typedef logic [APB_AW-3:0]       reg_idx_t;

  localparam func_t FUNC_ALLOC = 2'd0;
  localparam func_t FUNC_FREE  = 2'd1;
  localparam func_t FUNC_SETC  = 2'd2;

  localparam status_t STAT_OK       = 3'd0;
  localparam status_t STAT_EMPTY    = 3'd1;
  localparam status_t STAT_BADADDR  = 3'd2;
  localparam status_t STAT_SHARED   = 3'd3;
  localparam status_t STAT_OVERFLOW = 3'd4;

  localparam reg_idx_t REG_FIRST_USABLE = reg_idx_t'(0);

  localparam count_t NOT_SHARED = count_t'(-1);
  localparam depth_t DEP_FULL   = depth_t'(NUM_PAGES);
  localparam addr_t  OFF_MASK   = addr_t'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam addr_t  PAGE_LIMIT = addr_t'(NUM_PAGES);

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } spa_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_busy;
  } spa_sts_t;

endpackage
`default_nettype wire

// ===== hdl/spa_ifs.sv =====
// request and result channel interfaces
`default_nettype none
interface spa_in_if import spa_pkg::*; ();
  logic   valid;
  logic   ready;
  func_t  func;
  addr_t  address;
  count_t count_value;

  modport source (output valid, func, address, count_value, input ready);
  modport sink (input valid, func, address, count_value, output ready);
endinterface

interface spa_out_if import spa_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  addr_t   page_address;
  count_t  count_after;

  modport source (output valid, status, page_address, count_after, input ready);
  modport sink (input valid, status, page_address, count_after, output ready);
endinterface
`default_nettype wire

// ===== hdl/shared_page_frame_allocator.sv =====
// page frame allocator top level: free page stack with per-page share counts
// a request is taken by the accept step, and its result is registered by the execute step
// a new request is taken only after the previous one has executed: a share count read, then a write
// the result register lets a new request in while the previous result waits
// reset: after rst_n the share counts are set to not shared by a clearing
// pass over all 4096 pages, during which no request is taken; config stays open
`default_nettype none
module shared_page_frame_allocator import spa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  spa_in_if.sink                 in_ch,
  spa_out_if.source              out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [APB_AW-1:0] cfg_paddr,
  input  wire logic [APB_DW-1:0] cfg_pwdata,
  output logic      [APB_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  fup_t     fup;
  spa_cmd_t cmd;
  spa_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  spa_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fup         (fup)
  );

  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  spa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .fup              (fup),
    .in_func          (in_ch.func),
    .in_address       (in_ch.address),
    .in_count_value   (in_ch.count_value),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_status       (out_ch.status),
    .out_page_address (out_ch.page_address),
    .out_count_after  (out_ch.count_after),
    .sts              (sts)
  );

  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    !sts.clr_done |-> !in_ready)
    else $error("request taken during clearing pass");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("second request taken before first executed");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.exec))
    else $error("result beat without execute step");

  a_exec_not_over_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_ch.valid && !out_ch.ready))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

// ===== hdl/spa_cfg.sv =====
// apb configuration register block
`default_nettype none
module spa_cfg import spa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [APB_AW-1:0] cfg_paddr,
  input  wire logic [APB_DW-1:0] cfg_pwdata,
  output logic      [APB_DW-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output fup_t                   fup
);

  fup_t     fup_r;
  fup_t     fup_nxt;
  reg_idx_t widx;
  logic     wr;

  assign widx       = cfg_paddr[APB_AW-1:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign fup        = fup_r;

  always_comb begin
    fup_nxt = fup_r;
    if (wr && (widx == REG_FIRST_USABLE)) begin
      fup_nxt = cfg_pwdata[FUP_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (widx == REG_FIRST_USABLE) begin
      cfg_prdata = {{(APB_DW-FUP_W){1'b0}}, fup_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fup_r <= '0;
    end else begin
      fup_r <= fup_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/spa_ctrl.sv =====
// allocator sequencer: clearing pass, accept, execute
`default_nettype none
module spa_ctrl import spa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire spa_sts_t sts,
  output logic          in_ready,
  output spa_cmd_t      cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/spa_dp.sv =====
// allocator datapath: free stack, share counts, stack depth, result register
`default_nettype none
module spa_dp import spa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire spa_cmd_t cmd,
  input  wire fup_t     fup,
  input  wire func_t    in_func,
  input  wire addr_t    in_address,
  input  wire count_t   in_count_value,
  input  wire logic     out_ready,
  output logic          out_valid,
  output status_t       out_status,
  output addr_t         out_page_address,
  output count_t        out_count_after,
  output spa_sts_t      sts
);

  count_t share_mem [NUM_PAGES];
  page_t  stack_mem [NUM_PAGES];

  depth_t  depth_r;
  depth_t  depth_nxt;
  depth_t  clr_r;
  depth_t  clr_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    clr_done;

  func_t   func_r;
  page_t   pidx_r;
  count_t  cval_r;
  logic    free_bad_r;
  logic    range_bad_r;
  count_t  cnt_rd_r;
  page_t   stk_rd_r;

  status_t status_r;
  addr_t   paddr_r;
  count_t  count_r;

  addr_t   page_full;
  page_t   in_pidx;
  logic    range_bad;
  logic    free_bad;
  depth_t  top_idx;

  logic    sh_we;
  page_t   sh_wa;
  count_t  sh_wd;
  logic    st_we;
  status_t res_status;
  addr_t   res_addr;
  count_t  res_count;
  count_t  dec;

  assign page_full = addr_t'(in_address >> PAGE_SHIFT);
  assign in_pidx   = page_full[PG_W-1:0];
  assign range_bad = page_full >= PAGE_LIMIT;
  assign free_bad  = range_bad || ((in_address & OFF_MASK) != '0) ||
                     (page_full < addr_t'(fup));
  assign top_idx   = depth_t'(depth_r - 1'b1);
  assign clr_done  = (clr_r == DEP_FULL);
  assign dec       = count_t'(cnt_rd_r - count_t'(1));

  assign sts.clr_done = clr_done;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_page_address = paddr_r;
  assign out_count_after  = count_r;

  always_comb begin
    sh_we      = 1'b0;
    sh_wa      = clr_r[PG_W-1:0];
    sh_wd      = NOT_SHARED;
    st_we      = 1'b0;
    depth_nxt  = depth_r;
    clr_nxt    = clr_r;
    res_status = STAT_OK;
    res_addr   = '0;
    res_count  = '0;
    if (cmd.clear && !clr_done) begin
      sh_we   = 1'b1;
      clr_nxt = depth_t'(clr_r + 1'b1);
    end
    if (cmd.exec) begin
      case (func_r)
        FUNC_ALLOC: begin
          if (depth_r == '0) begin
            res_status = STAT_EMPTY;
          end else begin
            depth_nxt = top_idx;
            sh_we     = 1'b1;
            sh_wa     = stk_rd_r;
            sh_wd     = NOT_SHARED;
            res_addr  = addr_t'(addr_t'(stk_rd_r) << PAGE_SHIFT);
            res_count = NOT_SHARED;
          end
        end
        FUNC_FREE: begin
          if (free_bad_r) begin
            res_status = STAT_BADADDR;
          end else if (!cnt_rd_r[CNT_W-1]) begin
            sh_we      = 1'b1;
            sh_wa      = pidx_r;
            sh_wd      = (dec == '0) ? NOT_SHARED : dec;
            res_status = STAT_SHARED;
            res_count  = (dec == '0) ? NOT_SHARED : dec;
          end else if (depth_r == DEP_FULL) begin
            res_status = STAT_OVERFLOW;
            res_count  = cnt_rd_r;
          end else begin
            st_we     = 1'b1;
            depth_nxt = depth_t'(depth_r + 1'b1);
            res_count = cnt_rd_r;
          end
        end
        FUNC_SETC: begin
          if (range_bad_r) begin
            res_status = STAT_BADADDR;
          end else begin
            sh_we     = 1'b1;
            sh_wa     = pidx_r;
            sh_wd     = cval_r;
            res_count = cval_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sh_we) begin
      share_mem[sh_wa] <= sh_wd;
    end
    if (st_we) begin
      stack_mem[depth_r[PG_W-1:0]] <= pidx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cnt_rd_r <= share_mem[in_pidx];
      stk_rd_r <= stack_mem[top_idx[PG_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r      <= in_func;
      pidx_r      <= in_pidx;
      cval_r      <= in_count_value;
      free_bad_r  <= free_bad;
      range_bad_r <= range_bad;
    end
    if (cmd.exec) begin
      status_r <= res_status;
      paddr_r  <= res_addr;
      count_r  <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_shared_page_frame_allocator.sv =====
// self-checking testbench of the page frame allocator with a share-count predictor
module tb_shared_page_frame_allocator;
  import spa_pkg::*;

  localparam func_t FUNC_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    status_t status;
    addr_t   page_address;
    count_t  count_after;
  } alloc_result_t;

  class page_alloc_scoreboard;
    page_t         free_pages[NUM_PAGES];
    int unsigned   free_depth;
    count_t        share_count[NUM_PAGES];
    fup_t          first_usable;
    alloc_result_t awaited_results[$];
    int unsigned   n_requests;
    int unsigned   n_checked;
    int unsigned   n_mismatch;
    int unsigned   status_seen[5];

    function new();
      free_depth = 0;
      first_usable = '0;
      n_requests = 0;
      n_checked = 0;
      n_mismatch = 0;
      foreach (share_count[i]) share_count[i] = NOT_SHARED;
      foreach (free_pages[i]) free_pages[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void note_request(func_t f, addr_t a, count_t c);
      alloc_result_t r;
      logic [ADDR_W-PAGE_SHIFT-1:0] pg_full;
      logic in_range;
      page_t p;
      page_t popped;
      r.status = STAT_OK;
      r.page_address = '0;
      r.count_after = '0;
      pg_full = a[ADDR_W-1:PAGE_SHIFT];
      in_range = (pg_full < NUM_PAGES);
      p = page_t'(pg_full);
      n_requests++;
      case (f)
        FUNC_ALLOC: begin
          if (free_depth == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            free_depth--;
            popped = free_pages[free_depth];
            share_count[popped] = NOT_SHARED;
            r.page_address = addr_t'(popped) << PAGE_SHIFT;
            r.count_after = NOT_SHARED;
          end
        end
        FUNC_FREE: begin
          if ((a & OFF_MASK) != '0 || !in_range || p < first_usable) begin
            r.status = STAT_BADADDR;
          end else if (share_count[p] >= 0) begin
            // last sharer drops the page back to not shared
            if (share_count[p] == 1) share_count[p] = NOT_SHARED;
            else share_count[p] = share_count[p] - 1;
            r.status = STAT_SHARED;
            r.count_after = share_count[p];
          end else if (free_depth >= NUM_PAGES) begin
            r.status = STAT_OVERFLOW;
            r.count_after = share_count[p];
          end else begin
            free_pages[free_depth] = p;
            free_depth++;
            r.count_after = share_count[p];
          end
        end
        FUNC_SETC: begin
          if (!in_range) begin
            r.status = STAT_BADADDR;
          end else begin
            share_count[p] = c;
            r.count_after = c;
          end
        end
        default: ;
      endcase
      awaited_results.push_back(r);
    endfunction

    function void check_result(status_t s, addr_t a, count_t c);
      alloc_result_t e;
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d addr %h count %0d",
                 $time, s, a, c);
        n_mismatch++;
        return;
      end
      e = awaited_results.pop_front();
      n_checked++;
      if (e.status <= STAT_OVERFLOW) status_seen[e.status]++;
      if (s !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, s);
        n_mismatch++;
      end
      if (a !== e.page_address) begin
        $display("%0t: page_address expected %h actual %h", $time, e.page_address, a);
        n_mismatch++;
      end
      if (c !== e.count_after) begin
        $display("%0t: count_after expected %0d actual %0d", $time, e.count_after, c);
        n_mismatch++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  spa_in_if  in_ch();
  spa_out_if out_ch();

  shared_page_frame_allocator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  page_alloc_scoreboard sb;
  bit src_idle;
  bit sink_idle;
  bit long_hold;
  int unsigned stall_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // beats are sampled at the edge, before the drivers update
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_request(in_ch.func, in_ch.address, in_ch.count_value);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.status, out_ch.page_address, out_ch.count_after);
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("shared_page_frame_allocator regression: fail");
      $finish;
    end
  end

  // result side back-pressure
  initial begin : sink_proc
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  function automatic addr_t page_addr(int unsigned p);
    return addr_t'(p) << PAGE_SHIFT;
  endfunction

  // half the picks from a small window above the first usable page, so pages get reused
  function automatic int unsigned pick_page();
    int unsigned lo;
    int unsigned sel;
    lo = sb.first_usable;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, NUM_PAGES - 1);
    if (sel < 6) return $urandom_range(lo, (lo + 15 < NUM_PAGES) ? lo + 15 : NUM_PAGES - 1);
    return $urandom_range(lo, NUM_PAGES - 1);
  endfunction

  task automatic send_op(input func_t f, input addr_t a, input count_t c);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.address <= a;
    in_ch.count_value <= c;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic stream_stop();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_first_usable(input int unsigned v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_FIRST_USABLE, 2'b00};
    cfg_pwdata <= APB_DW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.first_usable = fup_t'(v);
  endtask

  task automatic send_random_op();
    int unsigned r;
    int unsigned sub;
    func_t  f;
    addr_t  a;
    count_t c;
    r = $urandom_range(0, 99);
    sub = $urandom_range(0, 9);
    a = $urandom();
    c = count_t'($urandom_range(0, 65535));
    if (r < 35) begin
      f = FUNC_ALLOC;
    end else if (r < 70) begin
      f = FUNC_FREE;
      if (sub == 1)
        a = page_addr(pick_page()) | addr_t'($urandom_range(1, 4095));
      else if (sub == 2)
        a = ($urandom() & ~OFF_MASK) | 32'h0100_0000;
      else if (sub != 0)
        a = page_addr(pick_page());
    end else if (r < 92) begin
      f = FUNC_SETC;
      if (sub != 0) a = page_addr(pick_page()) | addr_t'($urandom_range(0, 4095));
      sub = $urandom_range(0, 9);
      if (sub < 6) c = count_t'($urandom_range(0, 3));
      else if (sub < 8) c = NOT_SHARED;
    end else if (r < 96) begin
      f = FUNC_UNUSED;
    end else begin
      f = func_t'($urandom_range(0, 3));
    end
    send_op(f, a, c);
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) send_random_op();
    stream_stop();
    wait_idle();
  endtask

  initial begin : main_seq
    sb = new();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    long_hold = 1'b0;
    stall_cycles = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_ALLOC;
    in_ch.address <= '0;
    in_ch.count_value <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_first_usable(0);
    send_op(FUNC_ALLOC, 32'hFFFF_FFFF, NOT_SHARED);
    send_op(FUNC_FREE, 32'h0000_0000, '0);
    send_op(FUNC_FREE, 32'h0000_5001, '0);
    send_op(FUNC_FREE, 32'h0100_0000, '0);
    send_op(FUNC_FREE, 32'hFFFF_F000, '0);
    send_op(FUNC_SETC, 32'h0000_7ABC, 16'sd2);
    send_op(FUNC_FREE, 32'h0000_7000, '0);
    send_op(FUNC_FREE, 32'h0000_7000, '0);
    send_op(FUNC_FREE, 32'h0000_7000, '0);
    send_op(FUNC_FREE, 32'h0000_7000, '0);
    send_op(FUNC_SETC, 32'hFFFF_FFFF, 16'sd5);
    send_op(FUNC_SETC, 32'h00FF_F000, 16'sh7FFF);
    send_op(FUNC_FREE, 32'h00FF_F000, '0);
    send_op(FUNC_SETC, 32'h00FF_FFFF, 16'sh8000);
    send_op(FUNC_FREE, 32'h00FF_F000, 16'sh7FFF);
    send_op(FUNC_UNUSED, 32'hFFFF_FFFF, NOT_SHARED);
    send_op(FUNC_ALLOC, 32'h0000_0000, '0);
    send_op(FUNC_ALLOC, 32'h0000_0000, '0);
    send_op(FUNC_ALLOC, 32'h0000_0000, '0);
    send_op(FUNC_ALLOC, 32'h0000_0000, '0);
    send_op(FUNC_ALLOC, 32'h0000_0000, '0);
    send_op(FUNC_SETC, 32'h0000_3000, 16'sd0);
    send_op(FUNC_FREE, 32'h0000_3000, '0);
    stream_stop();
    wait_idle();

    write_first_usable(NUM_PAGES - 1);
    send_op(FUNC_FREE, page_addr(NUM_PAGES - 2), '0);
    send_op(FUNC_SETC, page_addr(100), 16'sd1);
    run_random(150);

    write_first_usable($urandom_range(2, NUM_PAGES - 3));
    run_random(100);
    // long receiver hold-off while requests keep coming
    long_hold = 1'b1;
    src_idle = 1'b0;
    repeat (40) send_random_op();
    src_idle = 1'b1;
    run_random(110);

    write_first_usable(1);
    run_random(150);

    src_idle = 1'b0;
    sink_idle = 1'b0;
    write_first_usable(0);
    run_random(200);

    repeat (8) @(posedge clk);
    $display("%0d requests over five first-usable settings, %0d results checked",
             sb.n_requests, sb.n_checked);
    $display("status mix: ok %0d, empty %0d, bad address %0d, shared %0d, overflow %0d",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_EMPTY], sb.status_seen[STAT_BADADDR],
             sb.status_seen[STAT_SHARED], sb.status_seen[STAT_OVERFLOW]);
    if (sb.n_mismatch == 0 && sb.awaited_results.size() == 0) begin
      $display("shared_page_frame_allocator regression: pass");
    end else begin
      $display("shared_page_frame_allocator regression: fail");
    end
    $finish;
  end

endmodule

// ===== shared_page_frame_allocator.f =====
hdl/spa_pkg.sv
hdl/spa_ifs.sv
hdl/spa_cfg.sv
hdl/spa_ctrl.sv
hdl/spa_dp.sv
hdl/shared_page_frame_allocator.sv
sim/tb_shared_page_frame_allocator.sv
